FILE: rtl/core/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg - shared definitions for the binomial-mod-prime block
// Field widths, modulus reset value and the sequencer state encoding.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // width of the input fields total and chosen
  localparam int unsigned FIELD_W = 20;
  // low bits of each input field that take part (index width)
  localparam int unsigned IDX_W   = 20;
  // modulus and residue width
  localparam int unsigned MOD_W   = 31;

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1000000007);

  typedef logic [MOD_W-1:0] residue_t;
  typedef logic [IDX_W-1:0] index_t;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_LOOP      = 7'b0000010,
    S_LOOP_WAIT = 7'b0000100,
    S_EXP       = 7'b0001000,
    S_EXP_WAIT  = 7'b0010000,
    S_FIN_WAIT  = 7'b0100000,
    S_DONE      = 7'b1000000
  } bmp_state_e;

endpackage

FILE: rtl/core/bmp_if.sv
// ----------------------------------------------------------------------------
// bmp_if - channel interfaces of the binomial-mod-prime block
// Valid/ready channels for the (total, chosen) items and for the results.
// ----------------------------------------------------------------------------
interface bmp_in_if import bmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] total;
  logic [FIELD_W-1:0] chosen;

  modport source (output valid, output total, output chosen, input ready);
  modport sink   (input valid, input total, input chosen, output ready);
endinterface

interface bmp_out_if import bmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/core/bmp_modmul.sv
// ----------------------------------------------------------------------------
// bmp_modmul - bit-serial modular multiplier
// Computes a * b mod p, one bit of b per cycle from the LSB. The multiplicand
// a must already be below p; b may be any value and is shifted out as it goes.
// ----------------------------------------------------------------------------
module bmp_modmul import bmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  residue_t a_i,
  input  residue_t b_i,
  input  residue_t p_i,
  output logic     busy_o,
  output residue_t prod_o
);

  residue_t acc_q, a_q, b_q;
  residue_t acc_red, dbl_red;
  logic [MOD_W:0] acc_sum, dbl_sum;

  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, a_q};
    dbl_sum = {a_q, 1'b0};
    // both operands are below p, so one subtraction brings the sum back in range
    if (acc_sum >= {1'b0, p_i}) begin
      acc_red = MOD_W'(acc_sum - {1'b0, p_i});
    end else begin
      acc_red = acc_sum[MOD_W-1:0];
    end
    if (dbl_sum >= {1'b0, p_i}) begin
      dbl_red = MOD_W'(dbl_sum - {1'b0, p_i});
    end else begin
      dbl_red = dbl_sum[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (start_i) begin
      b_q <= b_i;
    end else if (b_q != '0) begin
      b_q <= b_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
    end else if (b_q != '0) begin
      if (b_q[0]) begin
        acc_q <= acc_red;
      end
      a_q <= dbl_red;
    end
  end

  assign busy_o = (b_q != '0);
  assign prod_o = acc_q;

endmodule

FILE: rtl/core/binomial_mod_prime_top.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime_top - binomial coefficient modulo a configured prime
// Sequencer, modulus register and result register around two multipliers.
// ----------------------------------------------------------------------------
// One item (total n, chosen m) gives one result, n choose m mod modulus, or 0
// when m exceeds n or the modulus is below two. Items are handled one at a
// time. With k = min(m, n - m), the block forms the falling and rising
// products over k factors, then the Fermat inverse of the rising product
// and the final product. The two bit-serial multipliers retire one bit
// of their second operand per cycle and work side by side. A finished
// result waits in the output register while the next transaction is
// taken in.
// ----------------------------------------------------------------------------
module binomial_mod_prime_top import bmp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  residue_t        cfg_wdata_i,
  bmp_in_if.sink          item_i,
  bmp_out_if.source       result_o
);

  bmp_state_e state_q, state_d;
  residue_t   modulus_q;
  index_t     n_q, n_d, k_q, k_d, i_q, i_d;
  residue_t   num_q, num_d, den_q, den_d, acc_q, acc_d, exp_q, exp_d, res_q, res_d;
  residue_t   value_q;
  logic       out_valid_q, out_valid_d, out_load;

  logic       mul_start, busy0, busy1;
  residue_t   a0, b0, a1, b1, prod0, prod1;

  index_t     n_in, m_in;
  logic [IDX_W:0] twice_m;
  logic       item_acc;

  assign n_in     = item_i.total[IDX_W-1:0];
  assign m_in     = item_i.chosen[IDX_W-1:0];
  assign twice_m  = {m_in, 1'b0};
  assign item_acc = item_i.valid && item_i.ready;

  bmp_modmul u_mul0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a0),
    .b_i     (b0),
    .p_i     (modulus_q),
    .busy_o  (busy0),
    .prod_o  (prod0)
  );

  bmp_modmul u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a1),
    .b_i     (b1),
    .p_i     (modulus_q),
    .busy_o  (busy1),
    .prod_o  (prod1)
  );

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    k_d          = k_q;
    i_d          = i_q;
    num_d        = num_q;
    den_d        = den_q;
    acc_d        = acc_q;
    exp_d        = exp_q;
    res_d        = res_q;
    out_load     = 1'b0;
    item_i.ready = 1'b0;
    mul_start    = 1'b0;
    a0           = num_q;
    b0           = {{(MOD_W-IDX_W){1'b0}}, IDX_W'(n_q - i_q + IDX_W'(1))};
    a1           = den_q;
    b1           = {{(MOD_W-IDX_W){1'b0}}, i_q};

    case (state_q)
      S_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid) begin
          n_d   = n_in;
          k_d   = (twice_m > {1'b0, n_in}) ? IDX_W'(n_in - m_in) : m_in;
          i_d   = IDX_W'(1);
          num_d = MOD_W'(1);
          den_d = MOD_W'(1);
          if (modulus_q < MOD_W'(2) || m_in > n_in) begin
            res_d   = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (i_q > k_q) begin
          acc_d   = MOD_W'(1);
          exp_d   = modulus_q - MOD_W'(2);
          state_d = S_EXP;
        end else begin
          mul_start = 1'b1;
          state_d   = S_LOOP_WAIT;
        end
      end
      S_LOOP_WAIT: begin
        if (!busy0 && !busy1) begin
          num_d   = prod0;
          den_d   = prod1;
          i_d     = i_q + IDX_W'(1);
          state_d = S_LOOP;
        end
      end
      S_EXP: begin
        mul_start = 1'b1;
        if (exp_q == '0) begin
          // acc_q now holds the inverse of the rising product
          a0      = num_q;
          b0      = acc_q;
          b1      = '0;
          state_d = S_FIN_WAIT;
        end else begin
          a0      = acc_q;
          b0      = den_q;
          a1      = den_q;
          b1      = den_q;
          state_d = S_EXP_WAIT;
        end
      end
      S_EXP_WAIT: begin
        if (!busy0 && !busy1) begin
          if (exp_q[0]) begin
            acc_d = prod0;
          end
          den_d   = prod1;
          exp_d   = exp_q >> 1;
          state_d = S_EXP;
        end
      end
      S_FIN_WAIT: begin
        if (!busy0) begin
          res_d   = prod0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      modulus_q   <= MODULUS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    k_q   <= k_d;
    i_q   <= i_d;
    num_q <= num_d;
    den_q <= den_d;
    acc_q <= acc_d;
    exp_q <= exp_d;
    res_q <= res_d;
    if (out_load) begin
      value_q <= res_q;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.value = value_q;

  // residues stay reduced throughout the product loop
  a_loop_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOP |-> num_q < modulus_q && den_q < modulus_q)
    else $error("loop residue not reduced");

  // the factor counter never runs more than one past the symmetric count
  a_loop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOP |-> {1'b0, i_q} <= {1'b0, k_q} + {{IDX_W{1'b0}}, 1'b1})
    else $error("factor counter beyond symmetric count");

  // chosen above total goes straight to a zero result
  a_zero_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc && m_in > n_in |=> state_q == S_DONE && res_q == '0)
    else $error("chosen above total not mapped to zero");

  // a delivered result is a proper residue when the modulus is at least two
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && modulus_q >= MOD_W'(2) |-> value_q < modulus_q)
    else $error("result not below modulus");

endmodule
